@@ hw/rtl/bmc_pkg.sv @@
package bmc_pkg;

  localparam int MaskWidth = 64;
  localparam int MaskIdxW  = $clog2(MaskWidth);
  localparam int KeySpace  = 256;
  localparam int KeyW      = $clog2(KeySpace);
  localparam int LenW      = 7;
  localparam int PosW      = LenW + 2;
  localparam int NucCount  = 4;
  localparam int SpecialKeys = 5;

  typedef logic [MaskWidth-1:0] mask_t;

  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdLookup = 1'b1;

  localparam logic RegPatternLength = 1'b0;
  localparam logic RegForwardMode   = 1'b1;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrBackward = 2'd1;
  localparam logic [1:0] ErrEdge     = 2'd2;

  localparam logic [KeyW-1:0] KeyGapInit  = 8'd0;
  localparam logic [KeyW-1:0] KeyGapFinal = 8'd1;
  localparam logic [KeyW-1:0] KeyNotFinal = 8'd2;
  localparam logic [KeyW-1:0] KeyStartBit = 8'd3;
  localparam logic [KeyW-1:0] KeyLenOnes  = 8'd4;

  localparam logic [KeyW-1:0] WildChar = 8'h2A;

  localparam logic [KeyW-1:0] BaseChar [NucCount] = '{8'h41, 8'h43, 8'h47, 8'h54};

  typedef struct packed {
    logic            cmd;
    logic [KeyW-1:0] pattern_char;
    logic [KeyW-1:0] lookup_key;
  } req_t;

  typedef struct packed {
    logic [LenW-1:0] pattern_length;
    logic            forward_mode;
  } cfg_t;

  typedef struct packed {
    logic            we;
    logic [KeyW-1:0] addr;
    mask_t           data;
  } ram_wr_t;

  typedef struct packed {
    mask_t      mask;
    logic       entry_used;
    logic       pattern_ready;
    logic [1:0] error_code;
  } res_t;

  // nucleotides covered by a letter, bit order A C G T
  function automatic logic [NucCount-1:0] nuc_cover(input logic [KeyW-1:0] c);
    logic [NucCount-1:0] r;
    begin
      case (c)
        "A":     r = 4'b0001;
        "C":     r = 4'b0010;
        "G":     r = 4'b0100;
        "T":     r = 4'b1000;
        "N":     r = 4'b1111;
        "W":     r = 4'b1001;
        "S":     r = 4'b0110;
        "M":     r = 4'b0011;
        "K":     r = 4'b1100;
        "R":     r = 4'b0101;
        "Y":     r = 4'b1010;
        "B":     r = 4'b1110;
        "D":     r = 4'b1101;
        "H":     r = 4'b1011;
        "V":     r = 4'b0111;
        default: r = 4'b0000;
      endcase
      return r;
    end
  endfunction

  function automatic logic is_ambig(input logic [KeyW-1:0] c);
    logic r;
    begin
      case (c)
        "N", "W", "S", "M", "K", "R", "Y", "B", "D", "H", "V": r = 1'b1;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

  // single position bit, dropped outside the mask
  function automatic mask_t bit_at(input logic signed [PosW-1:0] p);
    mask_t m;
    begin
      m = '0;
      if (!p[PosW-1] && (p < $signed(PosW'(MaskWidth)))) begin
        m[p[MaskIdxW-1:0]] = 1'b1;
      end
      return m;
    end
  endfunction

endpackage

@@ hw/rtl/bmc_ram.sv @@
module bmc_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bmc_core.sv @@
module bmc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  bmc_pkg::req_t    req_i,
  input  bmc_pkg::cfg_t    cfg_i,
  input  bmc_pkg::mask_t   rdata_i,
  output bmc_pkg::ram_wr_t wr_o,
  output logic             done_o,
  output bmc_pkg::res_t    res_o
);

  bmc_pkg::mask_t nuc_q [bmc_pkg::NucCount];
  bmc_pkg::mask_t nuc_d [bmc_pkg::NucCount];
  bmc_pkg::mask_t gi_q, gi_d, gf_q, gf_d;
  logic [bmc_pkg::KeySpace-1:0] flags_q, flags_d;
  logic [bmc_pkg::LenW-1:0] load_pos_q, load_pos_d;
  logic run_q, run_d, complete_q, complete_d;
  logic done_q;
  bmc_pkg::res_t res_q, res_d;

  logic [bmc_pkg::LenW-1:0] len;
  logic signed [bmc_pkg::PosW-1:0] base_s, i_s, pos_f, pos_gi, pos_b, pos_c;
  logic start_pat, last;
  logic [bmc_pkg::NucCount-1:0] cov;
  logic [1:0] err;
  bmc_pkg::mask_t lk_mask;

  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len = bmc_pkg::LenW'(1);
    end else if (cfg_i.pattern_length > bmc_pkg::LenW'(bmc_pkg::MaskWidth)) begin
      len = bmc_pkg::LenW'(bmc_pkg::MaskWidth);
    end else begin
      len = cfg_i.pattern_length;
    end
  end

  assign base_s = $signed(bmc_pkg::PosW'(bmc_pkg::MaskWidth)) - $signed({2'b00, len});
  assign i_s    = $signed({2'b00, load_pos_q});
  assign pos_f  = base_s + i_s;
  assign pos_gi = pos_f - $signed(bmc_pkg::PosW'(1));
  assign pos_b  = $signed(bmc_pkg::PosW'(bmc_pkg::MaskWidth - 1)) - i_s;
  assign pos_c  = cfg_i.forward_mode ? pos_f : pos_b;
  assign last   = ({1'b0, load_pos_q} + 8'd1) >= {1'b0, len};
  assign start_pat = complete_q || (load_pos_q == '0);

  always_comb begin
    nuc_d      = nuc_q;
    gi_d       = gi_q;
    gf_d       = gf_q;
    flags_d    = flags_q;
    run_d      = run_q;
    complete_d = complete_q;
    load_pos_d = load_pos_q;
    wr_o       = '0;
    res_d      = '0;
    err        = bmc_pkg::ErrNone;
    cov        = '0;
    lk_mask    = '0;
    if (valid_i) begin
      if (req_i.cmd == bmc_pkg::CmdLoad) begin
        if (start_pat) begin
          for (int n = 0; n < bmc_pkg::NucCount; n++) begin
            nuc_d[n] = '0;
          end
          gi_d       = '0;
          gf_d       = '0;
          flags_d    = '0;
          run_d      = 1'b0;
          complete_d = 1'b0;
        end
        if (req_i.pattern_char == bmc_pkg::WildChar) begin
          if (!cfg_i.forward_mode) begin
            err = bmc_pkg::ErrBackward;
          end else if ((load_pos_q == '0) || last) begin
            err = bmc_pkg::ErrEdge;
          end
          if (!run_d) begin
            gi_d  = gi_d | bmc_pkg::bit_at(pos_gi);
            run_d = 1'b1;
          end
          for (int n = 0; n < bmc_pkg::NucCount; n++) begin
            nuc_d[n] = nuc_d[n] | bmc_pkg::bit_at(pos_f);
            flags_d[bmc_pkg::BaseChar[n]] = 1'b1;
          end
        end else begin
          if (run_d) begin
            gf_d  = gf_d | bmc_pkg::bit_at(pos_f);
            run_d = 1'b0;
          end
          cov = bmc_pkg::nuc_cover(req_i.pattern_char);
          if (cov != '0) begin
            for (int n = 0; n < bmc_pkg::NucCount; n++) begin
              if (cov[n]) begin
                nuc_d[n] = nuc_d[n] | bmc_pkg::bit_at(pos_c);
                flags_d[bmc_pkg::BaseChar[n]] = 1'b1;
              end
            end
          end else begin
            wr_o.we   = 1'b1;
            wr_o.addr = req_i.pattern_char;
            wr_o.data = (flags_d[req_i.pattern_char] ? rdata_i : '0)
                        | bmc_pkg::bit_at(pos_c);
            flags_d[req_i.pattern_char] = 1'b1;
          end
        end
        if (last) begin
          run_d      = 1'b0;
          complete_d = 1'b1;
          load_pos_d = '0;
          for (int k = 0; k < bmc_pkg::KeySpace; k++) begin
            if ((k < bmc_pkg::SpecialKeys) || bmc_pkg::is_ambig(bmc_pkg::KeyW'(k))) begin
              flags_d[k] = 1'b1;
            end
          end
        end else begin
          load_pos_d = load_pos_q + bmc_pkg::LenW'(1);
        end
        res_d.pattern_ready = complete_d;
        res_d.error_code    = err;
      end else if (complete_q) begin
        cov = bmc_pkg::nuc_cover(req_i.lookup_key);
        case (req_i.lookup_key)
          bmc_pkg::KeyGapInit:  lk_mask = gi_q;
          bmc_pkg::KeyGapFinal: lk_mask = gf_q;
          bmc_pkg::KeyNotFinal: lk_mask = ~gf_q;
          bmc_pkg::KeyStartBit: lk_mask = bmc_pkg::bit_at(base_s);
          bmc_pkg::KeyLenOnes:  lk_mask = ~(bmc_pkg::bit_at(base_s) - bmc_pkg::mask_t'(1));
          default: begin
            if ((cov != '0) && (bmc_pkg::is_ambig(req_i.lookup_key)
                                || flags_q[req_i.lookup_key])) begin
              for (int n = 0; n < bmc_pkg::NucCount; n++) begin
                if (cov[n]) begin
                  lk_mask = lk_mask | nuc_q[n];
                end
              end
            end else if (flags_q[req_i.lookup_key]) begin
              lk_mask = rdata_i;
            end
          end
        endcase
        res_d.mask          = lk_mask;
        res_d.entry_used    = flags_q[req_i.lookup_key];
        res_d.pattern_ready = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < bmc_pkg::NucCount; n++) begin
        nuc_q[n] <= '0;
      end
      gi_q       <= '0;
      gf_q       <= '0;
      flags_q    <= '0;
      load_pos_q <= '0;
      run_q      <= 1'b0;
      complete_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      nuc_q      <= nuc_d;
      gi_q       <= gi_d;
      gf_q       <= gf_d;
      flags_q    <= flags_d;
      load_pos_q <= load_pos_d;
      run_q      <= run_d;
      complete_q <= complete_d;
      done_q     <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ hw/rtl/bndm_mask_compiler.sv @@
// channel   | direction | handshake        | payload
// request   | in        | start / busy     | cmd_i, pattern_char_i, lookup_key_i
// result    | out       | done_o (strobe)  | mask_o, entry_used_o, pattern_ready_o,
//           |           |                  | error_code_o
// config    | in        | cfg_we_i         | cfg_idx_i, cfg_wdata_i
//
// Each request reads the character mask memory, then a load updates the state and may
// write the entry back, or a lookup forms its result; busy is high while that is done.
// The result is strobed on done_o in the cycle after that, alongside the next request.
// Reset clears the pattern state; the character mask memory holds no reset value.
// The receiver cannot stall; done_o lasts exactly one cycle.
module bndm_mask_compiler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [7:0]  pattern_char_i,
  input  logic [7:0]  lookup_key_i,
  output logic        done_o,
  output logic [63:0] mask_o,
  output logic        entry_used_o,
  output logic        pattern_ready_o,
  output logic [1:0]  error_code_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i
);

  bmc_pkg::cfg_t    cfg_q;
  bmc_pkg::req_t    req_q;
  logic             stage_q;
  logic             accept;
  logic [bmc_pkg::KeyW-1:0] raddr;
  bmc_pkg::mask_t   rdata;
  bmc_pkg::ram_wr_t wr;
  bmc_pkg::res_t    res;

  assign busy   = stage_q;
  assign accept = start && !stage_q;
  assign raddr  = (cmd_i == bmc_pkg::CmdLookup) ? lookup_key_i : pattern_char_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= bmc_pkg::LenW'(1);
      cfg_q.forward_mode   <= 1'b1;
      stage_q              <= 1'b0;
    end else begin
      stage_q <= accept;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bmc_pkg::RegPatternLength: cfg_q.pattern_length <= cfg_wdata_i;
          bmc_pkg::RegForwardMode:   cfg_q.forward_mode   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.cmd          <= cmd_i;
      req_q.pattern_char <= pattern_char_i;
      req_q.lookup_key   <= lookup_key_i;
    end
  end

  bmc_ram #(
    .Width(bmc_pkg::MaskWidth),
    .Depth(bmc_pkg::KeySpace)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bmc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_q),
    .req_i   (req_q),
    .cfg_i   (cfg_q),
    .rdata_i (rdata),
    .wr_o    (wr),
    .done_o  (done_o),
    .res_o   (res)
  );

  assign mask_o          = 64'(res.mask);
  assign entry_used_o    = res.entry_used;
  assign pattern_ready_o = res.pattern_ready;
  assign error_code_o    = res.error_code;

endmodule

@@ hw/rtl/bmc_checker.sv @@
module bmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [63:0] mask_o,
  input logic        entry_used_o,
  input logic        pattern_ready_o,
  input logic [1:0]  error_code_o
);

  a_done_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("request without result");

  a_done_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result without request");

  a_not_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !pattern_ready_o) |-> ((mask_o == 64'd0) && !entry_used_o))
    else $error("lookup before completion returned data");

  a_error_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (error_code_o != 2'd0)) |->
      ((mask_o == 64'd0) && !entry_used_o && (error_code_o != 2'd3)))
    else $error("bad error result");

endmodule

bind bndm_mask_compiler bmc_checker u_bmc_checker (.*);
